>>> hdl/luhs_pkg.sv
// Shared types, constants and helpers for the load-use hazard stall counter.
package luhs_pkg;

	localparam int unsigned NumRegsDef = 128;
	localparam int RegW   = 7;
	localparam int StampW = 32;
	localparam int WordW  = StampW + 1;

	typedef logic [RegW-1:0]   reg_t;
	typedef logic [StampW-1:0] stamp_t;
	typedef logic [1:0]        stall_t;

	localparam stamp_t MemLat = 32'd3;
	localparam stamp_t AluLat = 32'd2;

	localparam stall_t StallNone = 2'd0;
	localparam stall_t StallOne  = 2'd1;
	localparam stall_t StallTwo  = 2'd2;

	// newest stamp and producer kind seen for one source
	typedef struct packed {
		logic   kind;
		stamp_t stamp;
	} src_info_t;

	// scoreboard update of one retiring item
	typedef struct packed {
		logic   we;
		reg_t   dst_a;
		reg_t   dst_b;
		logic   kind;
		stamp_t stamp;
	} commit_t;

	function automatic logic reg_ok(reg_t r, int unsigned n);
		return (r != '0) && (32'(r) < n);
	endfunction

endpackage

>>> hdl/luhs_ram.sv
// Simple dual-port RAM, one write and one registered read port.
module luhs_ram #(
	parameter int DEPTH = 128,
	parameter int WIDTH = 33
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

>>> hdl/luhs_table.sv
// Per-register ready-stamp table: two write banks, replicated read ports, bypass.
module luhs_table import luhs_pkg::*; #(
	parameter int unsigned NUM_REGS = NumRegsDef
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      rd_en,
	input  reg_t      rd_addr [3],
	input  reg_t      src_s1  [3],
	input  commit_t   commit,
	output src_info_t info    [3]
);

	localparam int IW = $clog2(NUM_REGS);

	logic [WordW-1:0]    rd_a [3];
	logic [WordW-1:0]    rd_b [3];
	logic [WordW-1:0]    wdata;
	logic                wa, wb;
	logic [IW-1:0]       ia, ib;
	logic [NUM_REGS-1:0] va_q, selb_q;
	commit_t             last_q;

	// bank A takes dst_a, bank B takes dst_b; selb marks which one is newer,
	// and a set selb also means the bank B entry has been written
	assign wdata = {commit.kind, commit.stamp};
	assign wa    = commit.we && reg_ok(commit.dst_a, NUM_REGS);
	assign wb    = commit.we && reg_ok(commit.dst_b, NUM_REGS);
	assign ia    = IW'(commit.dst_a);
	assign ib    = IW'(commit.dst_b);

	for (genvar g = 0; g < 3; g++) begin : g_port
		luhs_ram #(.DEPTH(NUM_REGS), .WIDTH(WordW)) u_ram_a (
			.clk   (clk),
			.we    (wa),
			.waddr (ia),
			.wdata (wdata),
			.re    (rd_en),
			.raddr (IW'(rd_addr[g])),
			.rdata (rd_a[g])
		);
		luhs_ram #(.DEPTH(NUM_REGS), .WIDTH(WordW)) u_ram_b (
			.clk   (clk),
			.we    (wb),
			.waddr (ib),
			.wdata (wdata),
			.re    (rd_en),
			.raddr (IW'(rd_addr[g])),
			.rdata (rd_b[g])
		);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			va_q   <= '0;
			selb_q <= '0;
			last_q <= '0;
		end else begin
			// keep the commit of the read edge for as long as the read data waits
			if (rd_en) begin
				last_q <= commit;
			end
			if (wa) begin
				va_q[ia] <= 1'b1;
				if (!(wb && ib == ia)) begin
					selb_q[ia] <= 1'b0;
				end
			end
			if (wb) begin
				selb_q[ib] <= 1'b1;
			end
		end
	end

	// the item committed at the read edge is not in the read data yet
	always_comb begin
		logic [IW-1:0]    si;
		logic             hit;
		logic [WordW-1:0] word;
		for (int i = 0; i < 3; i++) begin
			si  = IW'(src_s1[i]);
			hit = last_q.we &&
				((reg_ok(last_q.dst_a, NUM_REGS) && src_s1[i] == last_q.dst_a) ||
				 (reg_ok(last_q.dst_b, NUM_REGS) && src_s1[i] == last_q.dst_b));
			if (hit) begin
				word = {last_q.kind, last_q.stamp};
			end else if (selb_q[si]) begin
				word = rd_b[i];
			end else begin
				word = va_q[si] ? rd_a[i] : '0;
			end
			info[i] = src_info_t'(word);
		end
	end

endmodule

>>> hdl/luhs_decide.sv
// Stall decision for one item from its source stamps and the carried state.
module luhs_decide import luhs_pkg::*; #(
	parameter int unsigned NUM_REGS = NumRegsDef
) (
	input  reg_t      src    [3],
	input  src_info_t info   [3],
	input  logic      is_mem,
	input  logic      is_store,
	input  stamp_t    cnt_next,
	input  stall_t    carry_q,
	input  logic      last_alu_q,
	output stall_t    stall,
	output stall_t    carry_next
);

	stall_t carry_dec;
	logic   alu_one, ltu_one, ltu_two;

	assign carry_dec = (carry_q != StallNone) ? carry_q - 2'd1 : StallNone;

	always_comb begin
		stamp_t d;
		logic   pend;
		alu_one = 1'b0;
		ltu_one = 1'b0;
		ltu_two = 1'b0;
		for (int i = 0; i < 3; i++) begin
			d    = info[i].stamp - cnt_next;
			pend = (d == 32'd1) || (d == 32'd2);
			// store data operand is forwarded late and never stalls
			if (reg_ok(src[i], NUM_REGS) && !(i == 0 && is_mem && is_store) && pend) begin
				if (!info[i].kind) begin
					alu_one = 1'b1;
				end else if (d == 32'd1) begin
					// a one-stall load-use right behind a two-stall one is absorbed
					if (carry_dec != StallOne || last_alu_q) begin
						ltu_one = 1'b1;
					end
				end else begin
					ltu_two = 1'b1;
				end
			end
		end
	end

	assign stall = ltu_two ? StallTwo :
		(ltu_one || alu_one) ? StallOne : StallNone;
	assign carry_next = ltu_two ? StallTwo : carry_dec;

endmodule

>>> hdl/load_use_hazard_stall_counter.sv
// Top level of the load-use hazard stall counter.
//
// One retired instruction per item on the input channel (item_valid /
// item_stall): three source and two destination register numbers (0 = none)
// plus load/store flags. For each item one result comes out on the result
// channel (res_valid / res_stall): the stalls charged to it (0, 1 or 2) and
// the running one-stall, two-stall and combined totals after it.
//
// Two register stages (s1, result): res_valid rises when the item moves from s1
// into the result register. Throughput is one item per cycle while res_stall is
// low: the table read is issued at acceptance, the decision is made in stage s1
// and lands in the result register. The read ports of the stamp RAMs are
// registered, so the item retired at the edge of a read is forwarded from a
// bypass register.
// Reset clears the counters, carried state, table valid bits and both
// channels; the table then reads as all zero with no clearing pass. While
// res_stall is high the result holds, s1 keeps one more item and then
// item_stall rises.
module load_use_hazard_stall_counter import luhs_pkg::*; #(
	parameter int unsigned NUM_REGS = NumRegsDef
) (
	input  logic   clk,
	input  logic   arst_n,
	// instruction channel
	input  logic   item_valid,
	output logic   item_stall,
	input  reg_t   src_a,
	input  reg_t   src_b,
	input  reg_t   src_c,
	input  reg_t   dst_a,
	input  reg_t   dst_b,
	input  logic   is_mem,
	input  logic   is_store,
	// result channel
	output logic   res_valid,
	input  logic   res_stall,
	output stall_t stall_cycles,
	output stamp_t one_stall_total,
	output stamp_t two_stall_total,
	output stamp_t hazard_total
);

	// stage s1: accepted item, waiting on registered table data
	logic      valid_s1;
	reg_t      src_s1 [3];
	reg_t      dst_a_s1, dst_b_s1;
	logic      mem_s1, store_s1;

	// architectural state
	stamp_t    cnt_q;
	stall_t    carry_q;
	logic      last_alu_q;
	stamp_t    one_q, two_q, haz_q;

	// result register
	logic      res_valid_q;
	stall_t    stall_q;

	logic      accept, adv, commit_en;
	reg_t      rd_addr [3];
	src_info_t info [3];
	stamp_t    cnt_next;
	stall_t    stall_d, carry_d;
	commit_t   commit;

	// s1 moves on whenever the result register is free or being drained
	assign adv        = !res_valid_q || !res_stall;
	assign item_stall = valid_s1 && !adv;
	assign accept     = item_valid && !item_stall;
	assign commit_en  = valid_s1 && adv;

	assign rd_addr[0] = src_a;
	assign rd_addr[1] = src_b;
	assign rd_addr[2] = src_c;

	assign cnt_next = cnt_q + 32'd1;

	always_comb begin
		commit       = '0;
		commit.we    = commit_en;
		commit.dst_a = dst_a_s1;
		commit.dst_b = dst_b_s1;
		commit.kind  = mem_s1;
		commit.stamp = cnt_next + (mem_s1 ? MemLat : AluLat);
	end

	luhs_table #(.NUM_REGS(NUM_REGS)) u_table (
		.clk     (clk),
		.arst_n  (arst_n),
		.rd_en   (accept),
		.rd_addr (rd_addr),
		.src_s1  (src_s1),
		.commit  (commit),
		.info    (info)
	);

	luhs_decide #(.NUM_REGS(NUM_REGS)) u_decide (
		.src        (src_s1),
		.info       (info),
		.is_mem     (mem_s1),
		.is_store   (store_s1),
		.cnt_next   (cnt_next),
		.carry_q    (carry_q),
		.last_alu_q (last_alu_q),
		.stall      (stall_d),
		.carry_next (carry_d)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (accept) begin
			valid_s1 <= 1'b1;
		end else if (adv) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			src_s1[0] <= src_a;
			src_s1[1] <= src_b;
			src_s1[2] <= src_c;
			dst_a_s1  <= dst_a;
			dst_b_s1  <= dst_b;
			mem_s1    <= is_mem;
			store_s1  <= is_store;
		end
	end

	// state and totals change only when an item retires into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q       <= '0;
			carry_q     <= StallNone;
			last_alu_q  <= 1'b0;
			one_q       <= '0;
			two_q       <= '0;
			haz_q       <= '0;
			res_valid_q <= 1'b0;
		end else begin
			if (adv) begin
				res_valid_q <= valid_s1;
			end
			if (commit_en) begin
				cnt_q      <= cnt_next;
				carry_q    <= carry_d;
				last_alu_q <= !mem_s1 && (dst_a_s1 != '0 || dst_b_s1 != '0);
				if (stall_d == StallOne) begin
					one_q <= one_q + 32'd1;
				end
				if (stall_d == StallTwo) begin
					two_q <= two_q + 32'd1;
				end
				if (stall_d != StallNone) begin
					haz_q <= haz_q + 32'd1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (commit_en) begin
			stall_q <= stall_d;
		end
	end

	assign res_valid       = res_valid_q;
	assign stall_cycles    = stall_q;
	assign one_stall_total = one_q;
	assign two_stall_total = two_q;
	assign hazard_total    = haz_q;

endmodule

>>> hdl/luhs_checker.sv
// Port-level checks for the load-use hazard stall counter, bound to the top.
module luhs_checker import luhs_pkg::*; (
	input logic   clk,
	input logic   arst_n,
	input logic   item_valid,
	input logic   item_stall,
	input logic   res_valid,
	input logic   res_stall,
	input stall_t stall_cycles,
	input stamp_t one_stall_total,
	input stamp_t two_stall_total,
	input stamp_t hazard_total
);

	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && res_stall |=> res_valid && $stable(stall_cycles))
		else $error("stalled result changed");

	a_haz_sum: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> hazard_total == 32'(one_stall_total + two_stall_total))
		else $error("hazard total is not the sum of the stall totals");

	a_one_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (one_stall_total == $past(one_stall_total) ||
			one_stall_total == 32'($past(one_stall_total) + 32'd1)))
		else $error("one-stall total moved by more than one");

	a_two_step: assert property (@(posedge clk) disable iff (!arst_n)
		1'b1 |=> (two_stall_total == $past(two_stall_total) ||
			two_stall_total == 32'($past(two_stall_total) + 32'd1)))
		else $error("two-stall total moved by more than one");

endmodule

bind load_use_hazard_stall_counter luhs_checker u_luhs_checker (.*);
